>>> rtl/rllm_pkg.sv
`default_nettype none

package rllm_pkg;

   // Width of the tick-count registers and the default elapsed counter size.
   localparam int TICK_W           = 16;
   localparam int LIMIT_W          = 6;
   localparam int COUNTER_BITS_DEF = 16;

   // Register reset values.
   localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 16'd3000;
   localparam logic [TICK_W-1:0]  PING_TICKS_RST    = 16'd2000;
   localparam logic [TICK_W-1:0]  WARN_TICKS_RST    = 16'd5000;
   localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST    = 6'd63;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_PING_TICKS    = 2'd1;
   localparam logic [1:0] CSR_WARN_TICKS    = 2'd2;
   localparam logic [1:0] CSR_LINE_LIMIT    = 2'd3;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // Reply patterns, first character in the top byte.
   localparam logic [39:0] PAT_READY = "READY";
   localparam logic [31:0] PAT_PONG  = "PONG";
   localparam logic [23:0] PAT_OK    = "OK,";
   localparam logic [31:0] PAT_ERR   = "ERR,";

   // Candidate flags: bit 0 READY, bit 1 PONG, bit 2 OK prefix, bit 3 ERR prefix.
   localparam logic [3:0] FLAGS_ALL = 4'hF;

   typedef enum logic [1:0] {
      MODE_AWAIT   = 2'd0,
      MODE_READY   = 2'd1,
      MODE_TIMEOUT = 2'd2
   } rllm_mode_type;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_READY    = 3'd1,
      KIND_PONG     = 3'd2,
      KIND_OK       = 3'd3,
      KIND_ERR      = 3'd4,
      KIND_UNKNOWN  = 3'd5,
      KIND_OVERLONG = 3'd6
   } rllm_kind_type;

   // Link status handed from the tracker to the top level.
   typedef struct packed {
      rllm_mode_type link_state;
      logic          became_ready;
      logic          timeout_event;
      logic          ping_request;
      logic          warn_emit;
   } rllm_status_type;

   // Result beat layout, last field in the lowest bits.
   typedef struct packed {
      logic [6:0]    pad;
      logic          warn_emit;
      logic          ping_request;
      logic          timeout_event;
      logic          became_ready;
      rllm_kind_type line_kind;
      rllm_mode_type link_state;
   } rllm_rsp_type;

   // Drops every candidate that the character at position pos rules out.
   function automatic logic [3:0] match_update(input logic [3:0] flags,
                                               input logic [5:0] pos,
                                               input logic [7:0] c);
      logic [3:0] f;
      f = flags;
      if (pos < 6'd5) begin
         if (c != PAT_READY[8*(3'd4 - pos[2:0]) +: 8]) f[0] = 1'b0;
      end else begin
         f[0] = 1'b0;
      end
      if (pos < 6'd4) begin
         if (c != PAT_PONG[8*(2'd3 - pos[1:0]) +: 8]) f[1] = 1'b0;
      end else begin
         f[1] = 1'b0;
      end
      if (pos < 6'd3) begin
         if (c != PAT_OK[8*(2'd2 - pos[1:0]) +: 8]) f[2] = 1'b0;
      end
      if (pos < 6'd4) begin
         if (c != PAT_ERR[8*(2'd3 - pos[1:0]) +: 8]) f[3] = 1'b0;
      end
      return f;
   endfunction

   function automatic rllm_kind_type classify(input logic [3:0] flags,
                                              input logic [5:0] count);
      rllm_kind_type k;
      if (flags[0] && count == 6'd5)      k = KIND_READY;
      else if (flags[1] && count == 6'd4) k = KIND_PONG;
      else if (flags[2] && count >= 6'd3) k = KIND_OK;
      else if (flags[3] && count >= 6'd4) k = KIND_ERR;
      else                                k = KIND_UNKNOWN;
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/rllm_line_parser.sv
`default_nettype none

module rllm_line_parser
   import rllm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                operation,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [LIMIT_W-1:0]  line_limit,
   output rllm_kind_type            line_kind
);

   logic [LIMIT_W-1:0] line_count_ff, line_count_in;
   logic [3:0]         match_flags_ff, match_flags_in;

   // The line text is never stored; only its length and the surviving candidates.
   always_comb begin
      line_kind      = KIND_NONE;
      line_count_in  = line_count_ff;
      match_flags_in = match_flags_ff;
      if (!operation) begin
         if (rx_byte == CHAR_LF) begin
            if (line_count_ff != '0) begin
               line_kind = classify(match_flags_ff, line_count_ff);
            end
            line_count_in  = '0;
            match_flags_in = FLAGS_ALL;
         end else if (rx_byte != CHAR_CR) begin
            if (line_count_ff >= line_limit) begin
               line_kind      = KIND_OVERLONG;
               line_count_in  = '0;
               match_flags_in = FLAGS_ALL;
            end else begin
               match_flags_in = match_update(match_flags_ff, line_count_ff, rx_byte);
               line_count_in  = line_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff  <= '0;
         match_flags_ff <= FLAGS_ALL;
      end else if (step) begin
         line_count_ff  <= line_count_in;
         match_flags_ff <= match_flags_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rllm_link_tracker.sv
`default_nettype none

module rllm_link_tracker
   import rllm_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               operation,
   input  wire rllm_kind_type      line_kind,
   input  wire logic [TICK_W-1:0]  timeout_ticks,
   input  wire logic [TICK_W-1:0]  ping_ticks,
   input  wire logic [TICK_W-1:0]  warn_ticks,
   output rllm_status_type         status
);

   localparam int CMP_W = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   rllm_mode_type           mode_ff, mode_in;
   logic [COUNTER_BITS-1:0] since_reply_ff, since_reply_in;
   logic [COUNTER_BITS-1:0] since_ping_ff, since_ping_in;
   logic [COUNTER_BITS-1:0] since_warn_ff, since_warn_in;
   logic [COUNTER_BITS-1:0] reply_inc, ping_inc, warn_inc;
   logic                    timeout_hit, ping_due, recognized, warn_try, warn_fire;

   // Saturating increments for tick beats.
   assign reply_inc = (since_reply_ff == CNT_MAX) ? since_reply_ff : since_reply_ff + 1'b1;
   assign ping_inc  = (since_ping_ff == CNT_MAX) ? since_ping_ff : since_ping_ff + 1'b1;
   assign warn_inc  = (since_warn_ff == CNT_MAX) ? since_warn_ff : since_warn_ff + 1'b1;

   assign timeout_hit = operation && (mode_ff == MODE_READY) &&
                        (CMP_W'(reply_inc) > CMP_W'(timeout_ticks));
   assign ping_due    = operation && (CMP_W'(ping_inc) > CMP_W'(ping_ticks));

   assign recognized = !operation && (line_kind == KIND_READY || line_kind == KIND_PONG ||
                                      line_kind == KIND_OK || line_kind == KIND_ERR);
   assign warn_try   = !operation && (line_kind == KIND_ERR || line_kind == KIND_UNKNOWN ||
                                      line_kind == KIND_OVERLONG);
   assign warn_fire  = warn_try && (CMP_W'(since_warn_ff) >= CMP_W'(warn_ticks));

   // Next state.
   always_comb begin
      mode_in        = mode_ff;
      since_reply_in = since_reply_ff;
      since_ping_in  = since_ping_ff;
      since_warn_in  = since_warn_ff;
      if (operation) begin
         since_reply_in = reply_inc;
         since_ping_in  = ping_due ? '0 : ping_inc;
         since_warn_in  = warn_inc;
         if (timeout_hit) mode_in = MODE_TIMEOUT;
      end else begin
         if (recognized) begin
            since_reply_in = '0;
            mode_in        = MODE_READY;
         end
         if (warn_fire) since_warn_in = '0;
      end
   end

   // Outputs.
   always_comb begin
      status.link_state    = mode_in;
      status.became_ready  = recognized && (mode_ff != MODE_READY);
      status.timeout_event = timeout_hit;
      status.ping_request  = ping_due;
      status.warn_emit     = warn_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_AWAIT;
         since_reply_ff <= '0;
         since_ping_ff  <= '0;
         since_warn_ff  <= CNT_MAX;
      end else if (step) begin
         mode_ff        <= mode_in;
         since_reply_ff <= since_reply_in;
         since_ping_ff  <= since_ping_in;
         since_warn_ff  <= since_warn_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/reply_line_link_monitor.sv
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  tuser: operation; tdata: rx_byte
// rsp      out        rsp_tvalid/rsp_tready  tdata: link_state, line_kind and event flags
// csr      in         csr_valid/csr_ready    csr_addr: register index; csr_wdata: value
//
// Every request beat gives exactly one response beat, passing through the input
// register and then the result register. One beat per cycle is sustained while
// the response side is not stalled: the two registers form a two-stage pipeline.
// Reset is synchronous and active high; it empties both stages, loads the
// register defaults and puts the link into the awaiting state.
// A stalled response holds its beat; the input register still takes one more beat.
`default_nettype none

module reply_line_link_monitor
   import rllm_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  wire logic         req_tuser,   // [0] operation (0 byte, 1 tick)

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // [1:0] link_state, [4:2] line_kind,
                                          // [5] became_ready, [6] timeout_event,
                                          // [7] ping_request, [8] warn_emit, rest zero

   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [15:0]  csr_wdata
);

   // Configuration registers.
   logic [TICK_W-1:0]  timeout_ticks_ff, ping_ticks_ff, warn_ticks_ff;
   logic [LIMIT_W-1:0] line_limit_ff;

   // Input stage.
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   // Result stage.
   logic         rsp_valid_ff;
   rllm_rsp_type rsp_data_ff, rsp_data_in;

   logic            step;
   rllm_kind_type   line_kind;
   rllm_status_type status;

   // The held beat is processed when the result register is free or being emptied.
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
         ping_ticks_ff    <= PING_TICKS_RST;
         warn_ticks_ff    <= WARN_TICKS_RST;
         line_limit_ff    <= LINE_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_addr)
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            CSR_PING_TICKS:    ping_ticks_ff    <= csr_wdata;
            CSR_WARN_TICKS:    warn_ticks_ff    <= csr_wdata;
            CSR_LINE_LIMIT:    line_limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   rllm_line_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .operation  (in_op_ff),
      .rx_byte    (in_byte_ff),
      .line_limit (line_limit_ff),
      .line_kind  (line_kind)
   );

   rllm_link_tracker #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .operation     (in_op_ff),
      .line_kind     (line_kind),
      .timeout_ticks (timeout_ticks_ff),
      .ping_ticks    (ping_ticks_ff),
      .warn_ticks    (warn_ticks_ff),
      .status        (status)
   );

   always_comb begin
      rsp_data_in.pad           = '0;
      rsp_data_in.warn_emit     = status.warn_emit;
      rsp_data_in.ping_request  = status.ping_request;
      rsp_data_in.timeout_event = status.timeout_event;
      rsp_data_in.became_ready  = status.became_ready;
      rsp_data_in.line_kind     = line_kind;
      rsp_data_in.link_state    = status.link_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/rllm_checker.sv
`default_nettype none

module rllm_checker
   import rllm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   rllm_rsp_type rsp_view;
   assign rsp_view = rsp_tdata;

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // Entering ready comes only from a recognized reply and leaves the link ready.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.became_ready |->
         rsp_view.link_state == MODE_READY &&
         (rsp_view.line_kind == KIND_READY || rsp_view.line_kind == KIND_PONG ||
          rsp_view.line_kind == KIND_OK || rsp_view.line_kind == KIND_ERR))
      else $error("became_ready without a recognized reply");

   // A timeout happens on a tick, which carries no line and no warning.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.timeout_event |->
         rsp_view.link_state == MODE_TIMEOUT && rsp_view.line_kind == KIND_NONE &&
         !rsp_view.warn_emit)
      else $error("timeout_event inconsistent with result");

   // With both stages stalled the input side must stop taking beats.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && !req_tready |=> !req_tready || rsp_tready)
      else $error("req accepted while pipeline full");

endmodule

bind reply_line_link_monitor rllm_checker u_rllm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
